// File: design/mrp_pkg.sv
// Package for the MaxRects sheet packer.
// Holds the sequencer state type and the shared codes; no dependencies.
package mrp_pkg;

  // Item function codes.
  localparam logic FUNC_START = 1'b0;
  localparam logic FUNC_PLACE = 1'b1;

  // Configuration register indexes, taken from the word address.
  localparam logic REG_SHEET_W = 1'b0;
  localparam logic REG_SHEET_H = 1'b1;

  // Saturation limit of the part counters.
  localparam logic [15:0] COUNT_MAX = 16'hFFFF;

  // Reset value of both sheet dimensions.
  localparam logic [15:0] SHEET_RESET = 16'd1000;

  // Sequencer states.
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_START,
    ST_PAREA,
    ST_S_INIT,
    ST_S_RD,
    ST_S_FIT,
    ST_S_CMP,
    ST_S_END,
    ST_P_RD,
    ST_P_EVAL,
    ST_P_PUSH,
    ST_CP_RD,
    ST_CP_WR,
    ST_PR_I,
    ST_PR_IL,
    ST_PR_J,
    ST_PR_JC,
    ST_CM_RD,
    ST_CM_WR,
    ST_SHEET,
    ST_DONE
  } st_e;

endpackage

// File: design/mrp_rect_ram.sv
// Rectangle table memory: one write port and one registered read port.
// Generic storage; depends on nothing else.
module mrp_rect_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and registered read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/mrp_mul.sv
// Shared multiplier of the packer with a registered product.
// Used for part area, free rectangle area and sheet area; no dependencies.
module mrp_mul #(
  parameter int W = 16
) (
  input  logic           clk_i,
  input  logic           en_i,
  input  logic [W-1:0]   a_i,
  input  logic [W-1:0]   b_i,
  output logic [2*W-1:0] prod_o
);

  logic [2*W-1:0] prod_q;

  // The product is held until the next enabled cycle.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= (2*W)'(a_i) * (2*W)'(b_i);
    end
  end

  assign prod_o = prod_q;

endmodule

// File: design/maxrects_rectangle_packer.sv
// MaxRects best-area-fit sheet packer, top level with the sequencer.
// Uses mrp_pkg, mrp_rect_ram (free table and split buffer) and mrp_mul.
//
// Usage: an input transaction with func 0 starts a new sheet from the
// sheet_width and sheet_height registers; func 1 places one part. Every
// input transaction yields exactly one output transaction with the placement
// and the running totals of the sheet. The block handles one item at a time
// and holds in_stall_o high until the sequencer is back in idle.
// A placement runs a search and a split pass over the live free rectangles,
// a copy of the m new pieces, pairwise pruning and compaction, all through
// one free table read port and one shared multiplier. The result sits in an
// output register; the next item is accepted while it waits. When
// out_stall_i is held, the sequencer waits in its last state until the
// register is free. Reset empties the free table (count zero), clears
// totals and overflow, and sets both sheet registers to 1000.
// Configuration is to be written over the APB port only while the block is
// idle; the block itself does not enforce it.
module maxrects_rectangle_packer
  import mrp_pkg::*;
#(
  parameter int MAX_FREE   = 64,
  parameter int COORD_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        func_i,
  input  logic [15:0] part_id_i,
  input  logic [15:0] part_width_i,
  input  logic [15:0] part_height_i,
  input  logic        allow_rotation_i,
  // Output channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        placed_o,
  output logic [15:0] placed_id_o,
  output logic [15:0] pos_x_o,
  output logic [15:0] pos_y_o,
  output logic [15:0] placed_width_o,
  output logic [15:0] placed_height_o,
  output logic        rotated_o,
  output logic [15:0] produced_count_o,
  output logic [15:0] unproduced_count_o,
  output logic [31:0] used_area_o,
  output logic [31:0] waste_area_o,
  output logic        table_overflow_o
);

  localparam int CW   = COORD_BITS;
  localparam int AW   = $clog2(MAX_FREE);
  localparam int CNTW = $clog2(MAX_FREE + 1);
  localparam int MW   = (COORD_BITS > 16) ? COORD_BITS : 16;
  localparam int RW   = 4 * CW;

  typedef struct packed {
    logic [CW-1:0] x;
    logic [CW-1:0] y;
    logic [CW-1:0] w;
    logic [CW-1:0] h;
  } rect_t;

  // True if rectangle b lies inside rectangle a.
  function automatic logic encloses(rect_t a, rect_t b);
    logic [CW:0] ar;
    logic [CW:0] ab;
    logic [CW:0] br;
    logic [CW:0] bb;
    ar = {1'b0, a.x} + {1'b0, a.w};
    ab = {1'b0, a.y} + {1'b0, a.h};
    br = {1'b0, b.x} + {1'b0, b.w};
    bb = {1'b0, b.y} + {1'b0, b.h};
    return (b.x >= a.x) && (b.y >= a.y) && (br <= ar) && (bb <= ab);
  endfunction

  st_e state_q, state_d;

  // Configuration and control state.
  logic [15:0]     sheet_width_q, sheet_height_q;
  logic [CNTW-1:0] count_q, i_q, j_q, k_q, wp_q, split_n_q;
  logic            found_q;
  logic [15:0]     placed_total_q, failed_total_q;
  logic [31:0]     area_total_q;
  logic            overflow_q;
  logic            out_valid_q;

  // Item and working payload.
  logic [15:0]     id_q;
  logic [CW-1:0]   pw_q, ph_q;
  logic            rot_q;
  logic [2*MW-1:0] parea_q, best_q;
  logic            up_q, side_q, turned_q;
  rect_t           cur_q, pick_q, ri_q;
  logic [4:0]      mask_q;

  // Output register.
  logic            o_placed_q, o_rot_q, o_ovf_q;
  logic [15:0]     o_id_q, o_x_q, o_y_q, o_w_q, o_h_q, o_prod_q, o_unprod_q;
  logic [31:0]     o_used_q, o_waste_q;

  // Memory and multiplier ports.
  logic            f_we, s_we, mul_en;
  logic [AW-1:0]   f_waddr, f_raddr, s_waddr, s_raddr;
  logic [RW:0]     f_wdata, f_rdata;
  logic [RW-1:0]   s_wdata, s_rdata;
  logic [MW-1:0]   mul_a, mul_b;
  logic [2*MW-1:0] prod;

  mrp_rect_ram #(.DEPTH(MAX_FREE), .WIDTH(RW + 1)) u_free_ram (
    .clk_i   (clk_i),
    .we_i    (f_we),
    .waddr_i (f_waddr),
    .wdata_i (f_wdata),
    .raddr_i (f_raddr),
    .rdata_o (f_rdata)
  );

  mrp_rect_ram #(.DEPTH(MAX_FREE), .WIDTH(RW)) u_split_ram (
    .clk_i   (clk_i),
    .we_i    (s_we),
    .waddr_i (s_waddr),
    .wdata_i (s_wdata),
    .raddr_i (s_raddr),
    .rdata_o (s_rdata)
  );

  mrp_mul #(.W(MW)) u_mul (
    .clk_i  (clk_i),
    .en_i   (mul_en),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  // Decoded read data; the top bit of a free table word marks a removed entry.
  rect_t f_rect, s_rect;
  logic  f_dead;
  assign f_dead = f_rdata[RW];
  assign f_rect = rect_t'(f_rdata[RW-1:0]);
  assign s_rect = rect_t'(s_rdata);

  // Handshakes and loop ends.
  logic in_fire, out_free, room;
  logic i_end, j_end, cp_end, cm_end;
  assign in_fire  = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;
  assign room     = split_n_q < CNTW'(MAX_FREE);
  assign i_end    = i_q >= count_q;
  assign j_end    = j_q >= count_q;
  assign cp_end   = k_q >= split_n_q;
  assign cm_end   = k_q >= count_q;

  // Fit test and leftover compare of the search.
  logic            fit_up, fit_side, better;
  logic [2*MW-1:0] left_area;
  assign fit_up    = (pw_q <= f_rect.w) && (ph_q <= f_rect.h);
  assign fit_side  = rot_q && (ph_q <= f_rect.w) && (pw_q <= f_rect.h);
  assign left_area = prod - parea_q;
  assign better    = (up_q || side_q) && (!found_q || (left_area < best_q));

  // Overlap of a free rectangle with the placement and its split pieces.
  logic [CW:0] rr, rb, pr, pb, cr, cb;
  logic        overlap;
  logic [4:0]  mask_new, low_bit, mask_rest;
  assign rr = {1'b0, f_rect.x} + {1'b0, f_rect.w};
  assign rb = {1'b0, f_rect.y} + {1'b0, f_rect.h};
  assign pr = {1'b0, pick_q.x} + {1'b0, pick_q.w};
  assign pb = {1'b0, pick_q.y} + {1'b0, pick_q.h};
  assign cr = {1'b0, cur_q.x} + {1'b0, cur_q.w};
  assign cb = {1'b0, cur_q.y} + {1'b0, cur_q.h};
  assign overlap = !((rr <= {1'b0, pick_q.x}) || (pr <= {1'b0, f_rect.x}) ||
                     (rb <= {1'b0, pick_q.y}) || (pb <= {1'b0, f_rect.y}));
  // Bit 0 keeps the whole rectangle; bits 1 to 4 are top, bottom, left, right.
  assign mask_new = overlap ? {pr < rr, pick_q.x > f_rect.x, pb < rb,
                               pick_q.y > f_rect.y, 1'b0} : 5'b00001;
  assign low_bit   = mask_q & (~mask_q + 5'd1);
  assign mask_rest = mask_q & ~low_bit;

  // Piece selected for this push.
  rect_t piece;
  always_comb begin
    piece = cur_q;
    case (low_bit)
      5'b00010: piece.h = pick_q.y - cur_q.y;
      5'b00100: begin
        piece.y = pb[CW-1:0];
        piece.h = CW'(cb - pb);
      end
      5'b01000: piece.w = pick_q.x - cur_q.x;
      5'b10000: begin
        piece.x = pr[CW-1:0];
        piece.w = CW'(cr - pr);
      end
      default: piece = cur_q;
    endcase
  end

  // Containment tests of the pruning pass.
  logic enc_ij, enc_ji;
  assign enc_ij = encloses(ri_q, f_rect);
  assign enc_ji = encloses(f_rect, ri_q);

  // Sheet area and waste at the end of an item.
  logic [31:0] sheet_area, waste;
  assign sheet_area = prod[31:0];
  assign waste = (sheet_area > area_total_q) ? (sheet_area - area_total_q) : 32'd0;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = (func_i == FUNC_START) ? ST_START : ST_PAREA;
        end
      end
      ST_START:  state_d = ST_SHEET;
      ST_PAREA:  state_d = ST_S_INIT;
      ST_S_INIT: state_d = ST_S_RD;
      ST_S_RD:   state_d = i_end ? ST_S_END : ST_S_FIT;
      ST_S_FIT:  state_d = ST_S_CMP;
      ST_S_CMP:  state_d = ST_S_RD;
      ST_S_END:  state_d = found_q ? ST_P_RD : ST_SHEET;
      ST_P_RD:   state_d = i_end ? ST_CP_RD : ST_P_EVAL;
      ST_P_EVAL: state_d = ST_P_PUSH;
      ST_P_PUSH: state_d = (mask_rest == 5'd0) ? ST_P_RD : ST_P_PUSH;
      ST_CP_RD:  state_d = cp_end ? ST_PR_I : ST_CP_WR;
      ST_CP_WR:  state_d = ST_CP_RD;
      ST_PR_I:   state_d = i_end ? ST_CM_RD : ST_PR_IL;
      ST_PR_IL:  state_d = f_dead ? ST_PR_I : ST_PR_J;
      ST_PR_J:   state_d = j_end ? ST_PR_I : ST_PR_JC;
      ST_PR_JC: begin
        if (!f_dead && !enc_ij && enc_ji) begin
          state_d = ST_PR_I;
        end else begin
          state_d = ST_PR_J;
        end
      end
      ST_CM_RD:  state_d = cm_end ? ST_SHEET : ST_CM_WR;
      ST_CM_WR:  state_d = ST_CM_RD;
      ST_SHEET:  state_d = ST_DONE;
      ST_DONE:   state_d = out_free ? ST_IDLE : ST_DONE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Memory, multiplier and handshake controls.
  always_comb begin
    f_we    = 1'b0;
    f_waddr = '0;
    f_wdata = '0;
    f_raddr = '0;
    s_we    = 1'b0;
    s_waddr = split_n_q[AW-1:0];
    s_wdata = piece;
    s_raddr = k_q[AW-1:0];
    mul_en  = 1'b0;
    mul_a   = '0;
    mul_b   = '0;
    case (state_q)
      ST_START: begin
        f_we    = 1'b1;
        f_wdata = {1'b0, CW'(0), CW'(0), CW'(sheet_width_q), CW'(sheet_height_q)};
      end
      ST_PAREA: begin
        mul_en = 1'b1;
        mul_a  = MW'(pw_q);
        mul_b  = MW'(ph_q);
      end
      ST_S_RD, ST_P_RD, ST_PR_I: f_raddr = i_q[AW-1:0];
      ST_S_FIT: begin
        mul_en = 1'b1;
        mul_a  = MW'(f_rect.w);
        mul_b  = MW'(f_rect.h);
      end
      ST_P_PUSH: s_we = (mask_q != 5'd0) && room;
      ST_CP_WR: begin
        f_we    = 1'b1;
        f_waddr = k_q[AW-1:0];
        f_wdata = {1'b0, s_rect};
      end
      ST_PR_J: f_raddr = j_q[AW-1:0];
      ST_PR_JC: begin
        if (!f_dead && enc_ij) begin
          f_we    = 1'b1;
          f_waddr = j_q[AW-1:0];
          f_wdata = {1'b1, f_rect};
        end else if (!f_dead && enc_ji) begin
          f_we    = 1'b1;
          f_waddr = i_q[AW-1:0];
          f_wdata = {1'b1, ri_q};
        end
      end
      ST_CM_RD: f_raddr = k_q[AW-1:0];
      ST_CM_WR: begin
        f_we    = !f_dead;
        f_waddr = wp_q[AW-1:0];
        f_wdata = {1'b0, f_rect};
      end
      ST_SHEET: begin
        mul_en = 1'b1;
        mul_a  = MW'(sheet_width_q);
        mul_b  = MW'(sheet_height_q);
      end
      default: ;
    endcase
  end

  assign in_stall_o = (state_q != ST_IDLE);

  // Control registers, counters and totals.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      sheet_width_q  <= SHEET_RESET;
      sheet_height_q <= SHEET_RESET;
      count_q        <= '0;
      i_q            <= '0;
      j_q            <= '0;
      k_q            <= '0;
      wp_q           <= '0;
      split_n_q      <= '0;
      found_q        <= 1'b0;
      placed_total_q <= '0;
      failed_total_q <= '0;
      area_total_q   <= '0;
      overflow_q     <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_SHEET_W) begin
          sheet_width_q <= pwdata[15:0];
        end else begin
          sheet_height_q <= pwdata[15:0];
        end
      end
      // The result is valid from hand-over until the receiver takes it.
      if ((state_q == ST_DONE) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: if (in_fire) found_q <= 1'b0;
        ST_START: begin
          count_q        <= CNTW'(1);
          placed_total_q <= '0;
          failed_total_q <= '0;
          area_total_q   <= '0;
          overflow_q     <= 1'b0;
        end
        ST_S_INIT: i_q <= '0;
        ST_S_CMP: begin
          if (better) found_q <= 1'b1;
          i_q <= i_q + CNTW'(1);
        end
        ST_S_END: begin
          if (found_q) begin
            if (placed_total_q != COUNT_MAX) placed_total_q <= placed_total_q + 16'd1;
            area_total_q <= area_total_q + parea_q[31:0];
          end else if (failed_total_q != COUNT_MAX) begin
            failed_total_q <= failed_total_q + 16'd1;
          end
          i_q       <= '0;
          split_n_q <= '0;
        end
        ST_P_RD: if (i_end) k_q <= '0;
        ST_P_PUSH: begin
          if (mask_q != 5'd0) begin
            if (room) split_n_q <= split_n_q + CNTW'(1);
            else overflow_q <= 1'b1;
          end
          if (mask_rest == 5'd0) i_q <= i_q + CNTW'(1);
        end
        ST_CP_RD: begin
          if (cp_end) begin
            count_q <= split_n_q;
            i_q     <= '0;
          end
        end
        ST_CP_WR: k_q <= k_q + CNTW'(1);
        ST_PR_I: begin
          if (i_end) begin
            k_q  <= '0;
            wp_q <= '0;
          end
        end
        ST_PR_IL: begin
          if (f_dead) i_q <= i_q + CNTW'(1);
          else j_q <= i_q + CNTW'(1);
        end
        ST_PR_J: if (j_end) i_q <= i_q + CNTW'(1);
        ST_PR_JC: begin
          if (!f_dead && !enc_ij && enc_ji) i_q <= i_q + CNTW'(1);
          else j_q <= j_q + CNTW'(1);
        end
        ST_CM_RD: if (cm_end) count_q <= wp_q;
        ST_CM_WR: begin
          if (!f_dead) wp_q <= wp_q + CNTW'(1);
          k_q <= k_q + CNTW'(1);
        end
        default: ;
      endcase
    end
  end

  // Item and working payload registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          id_q     <= part_id_i;
          pw_q     <= CW'(part_width_i);
          ph_q     <= CW'(part_height_i);
          rot_q    <= allow_rotation_i;
          pick_q   <= '0;
          turned_q <= 1'b0;
        end
      end
      ST_S_INIT: parea_q <= prod;
      ST_S_FIT: begin
        cur_q  <= f_rect;
        up_q   <= fit_up;
        side_q <= fit_side;
      end
      ST_S_CMP: begin
        if (better) begin
          best_q   <= left_area;
          pick_q.x <= cur_q.x;
          pick_q.y <= cur_q.y;
          pick_q.w <= up_q ? pw_q : ph_q;
          pick_q.h <= up_q ? ph_q : pw_q;
          turned_q <= !up_q;
        end
      end
      ST_P_EVAL: begin
        cur_q  <= f_rect;
        mask_q <= mask_new;
      end
      ST_P_PUSH: mask_q <= mask_rest;
      ST_PR_IL:  ri_q <= f_rect;
      ST_DONE: begin
        if (out_free) begin
          o_placed_q <= found_q;
          o_id_q     <= id_q;
          o_x_q      <= 16'(pick_q.x);
          o_y_q      <= 16'(pick_q.y);
          o_w_q      <= 16'(pick_q.w);
          o_h_q      <= 16'(pick_q.h);
          o_rot_q    <= turned_q;
          o_prod_q   <= placed_total_q;
          o_unprod_q <= failed_total_q;
          o_used_q   <= area_total_q;
          o_waste_q  <= waste;
          o_ovf_q    <= overflow_q;
        end
      end
      default: ;
    endcase
  end

  // Configuration read back.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_SHEET_W) ? {16'd0, sheet_width_q} : {16'd0, sheet_height_q};

  // Output channel.
  assign out_valid_o        = out_valid_q;
  assign placed_o           = o_placed_q;
  assign placed_id_o        = o_id_q;
  assign pos_x_o            = o_x_q;
  assign pos_y_o            = o_y_q;
  assign placed_width_o     = o_w_q;
  assign placed_height_o    = o_h_q;
  assign rotated_o          = o_rot_q;
  assign produced_count_o   = o_prod_q;
  assign unproduced_count_o = o_unprod_q;
  assign used_area_o        = o_used_q;
  assign waste_area_o       = o_waste_q;
  assign table_overflow_o   = o_ovf_q;

endmodule
